[src/hptc_pkg.sv]
// shared types and constants of the humidity / pressure / temperature compensation unit
package hptc_pkg;

	localparam int DIV_BITS   = 64;
	localparam int P_FINE_OFS = 128000;
	localparam int H_FINE_OFS = 76800;
	localparam int HUM_MAX    = 419430400;

	typedef enum logic [2:0] {
		REG_TEMP   = 3'd0,
		REG_PRES_A = 3'd1,
		REG_PRES_B = 3'd2,
		REG_PRES_C = 3'd3,
		REG_HUM_A  = 3'd4,
		REG_HUM_B  = 3'd5
	} reg_idx_t;

	// results and flags that ride along with the pressure divide
	typedef struct packed {
		logic signed [31:0] temp;
		logic [16:0]        hum;
		logic               qneg;
		logic               dz;
	} side_t;

	typedef struct packed {
		logic signed [31:0] temp;
		logic [23:0]        pres;
		logic [16:0]        hum;
	} result_t;

endpackage

[src/hptc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with side payload
module hptc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  start,
	input  logic [63:0]           num,
	input  logic [30:0]           den,
	input  hptc_pkg::side_t       side,
	output logic                  fin,
	output logic [63:0]           quo,
	output hptc_pkg::side_t       fin_side
);

	logic                  vld_s  [0:hptc_pkg::DIV_BITS];
	logic [63:0]           nq_s   [0:hptc_pkg::DIV_BITS];
	logic [30:0]           rem_s  [0:hptc_pkg::DIV_BITS];
	logic [30:0]           den_s  [0:hptc_pkg::DIV_BITS];
	hptc_pkg::side_t       side_s [0:hptc_pkg::DIV_BITS];

	assign vld_s[0]  = start;
	assign nq_s[0]   = num;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < hptc_pkg::DIV_BITS; k++) begin : g_step
		logic [31:0] sh;
		logic [31:0] dif;
		logic        ge;

		always_comb begin
			sh  = {1'b0, rem_s[k]} << 1 | {31'd0, nq_s[k][63]};
			dif = sh - {1'b0, den_s[k]};
			ge  = (sh >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? dif[30:0] : sh[30:0];
				nq_s[k+1]   <= {nq_s[k][62:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign fin      = vld_s[hptc_pkg::DIV_BITS];
	assign quo      = nq_s[hptc_pkg::DIV_BITS];
	assign fin_side = side_s[hptc_pkg::DIV_BITS];

endmodule

[src/humidity_pressure_temp_compensation_unit.sv]
// top level: integer compensation of raw temperature, pressure and humidity samples
//
// Input channel sample_valid/sample_ready carries one raw triple per beat;
// output channel result_valid/result_ready returns one compensated triple per
// beat, in order. Coefficients are to be loaded through the APB port (64-bit
// data, register i at byte address 8*i) while the unit is idle; the unit itself
// does not enforce this. Throughput is one sample per cycle while the output
// buffer has room. The pipeline has eleven stages of fine temperature,
// humidity and the pressure numerator/divisor, 64 stages of the pressure
// divider (one quotient bit each), and four stages of pressure correction.
// A two-beat output buffer sits after the pipeline; sample_ready drops only
// when both buffer entries are full, and then the whole pipeline holds its
// contents until a result is taken. Nothing is lost or repeated on a stall.
// Reset clears all coefficients to zero and empties pipeline and buffer.
module humidity_pressure_temp_compensation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  logic [15:0]        raw_humidity,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] temperature_centi,
	output logic [23:0]        pressure_pa,
	output logic [16:0]        humidity_q10,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	// coefficient registers
	logic [47:0] tc_q, pa_q, pb_q, pc_q;
	logic [39:0] ha_q;
	logic [23:0] hb_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
			ha_q <= '0;
			hb_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (hptc_pkg::reg_idx_t'(paddr[5:3]))
				hptc_pkg::REG_TEMP:   tc_q <= pwdata[47:0];
				hptc_pkg::REG_PRES_A: pa_q <= pwdata[47:0];
				hptc_pkg::REG_PRES_B: pb_q <= pwdata[47:0];
				hptc_pkg::REG_PRES_C: pc_q <= pwdata[47:0];
				hptc_pkg::REG_HUM_A:  ha_q <= pwdata[39:0];
				hptc_pkg::REG_HUM_B:  hb_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (hptc_pkg::reg_idx_t'(paddr[5:3]))
			hptc_pkg::REG_TEMP:   prdata = {16'd0, tc_q};
			hptc_pkg::REG_PRES_A: prdata = {16'd0, pa_q};
			hptc_pkg::REG_PRES_B: prdata = {16'd0, pb_q};
			hptc_pkg::REG_PRES_C: prdata = {16'd0, pc_q};
			hptc_pkg::REG_HUM_A:  prdata = {24'd0, ha_q};
			hptc_pkg::REG_HUM_B:  prdata = {40'd0, hb_q};
			default:              prdata = '0;
		endcase
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [7:0]  h6;
	logic signed [11:0] h4, h5;

	assign t1 = tc_q[15:0];
	assign t2 = tc_q[31:16];
	assign t3 = tc_q[47:32];
	assign p1 = pa_q[15:0];
	assign p2 = pa_q[31:16];
	assign p3 = pa_q[47:32];
	assign p4 = pb_q[15:0];
	assign p5 = pb_q[31:16];
	assign p6 = pb_q[47:32];
	assign p7 = pc_q[15:0];
	assign p8 = pc_q[31:16];
	assign p9 = pc_q[47:32];
	assign h1 = ha_q[7:0];
	assign h2 = ha_q[23:8];
	assign h3 = ha_q[31:24];
	assign h6 = ha_q[39:32];
	assign h4 = hb_q[11:0];
	assign h5 = hb_q[23:12];

	// flow control: the pipeline moves unless the output buffer is full
	logic [1:0] cnt_q;
	logic       en;

	assign en           = (cnt_q != 2'd2);
	assign sample_ready = en;

	logic [11:1]  vld_s;
	logic [79:76] vldq_s;
	logic         div_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vldq_s <= '0;
		end else if (en) begin
			vld_s  <= {vld_s[10:1], sample_valid};
			vldq_s <= {vldq_s[78:76], div_fin};
		end
	end

	// stage 1: temperature differences
	logic signed [18:0] a1_c, a1_s1;
	logic signed [17:0] b1_c, b1_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8;
	logic [15:0]        rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;

	always_comb begin
		a1_c = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		b1_c = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
	end

	// stages 2 to 5: fine temperature
	logic signed [34:0] m1_s2;
	logic signed [35:0] sq_s2;
	logic signed [23:0] ta_s3, sq12_c;
	logic signed [39:0] tb_s3;
	logic signed [24:0] fine_s4;
	logic signed [28:0] ft_c;
	logic signed [31:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic signed [25:0] pv_s5, hv_s5;

	always_comb begin
		sq12_c = 24'(sq_s2 >>> 12);
		ft_c   = 29'(fine_s4) * 29'sd5 + 29'sd128;
	end

	// stages 6 to 11: pressure numerator, divisor and humidity
	logic signed [51:0] aa_s6;
	logic signed [41:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7;
	logic signed [37:0] hx_c, hx_s6;
	logic signed [33:0] m6_s6;
	logic signed [35:0] m3_s6;
	logic signed [63:0] bb6_s7, bb3_s7;
	logic signed [22:0] x_s7, x_s8;
	logic signed [23:0] e6_c, e3_c;
	logic signed [47:0] y1_s7;
	logic signed [63:0] bs_s8;
	logic signed [57:0] a2_s8;
	logic signed [35:0] y0_c;
	logic signed [51:0] y2_s8;
	logic [63:0]        xs_c, pp_c;
	logic [20:0]        pd_c;
	logic signed [30:0] den_s9, den_s10;
	logic [63:0]        diff_s9;
	logic signed [37:0] y_c;
	logic signed [59:0] hxy_s9, hxy_s10, hxy_s11;
	logic [63:0]        num_s10;
	logic signed [63:0] sx_c;
	logic [63:0]        ll_s10;
	logic [31:0]        hl_s10;
	logic [63:0]        nmag_s11;
	logic [30:0]        dmag_s11;
	logic               qneg_s11, dz_s11;
	logic [63:0]        sq_c, t_c, u_s11;

	always_comb begin
		hx_c = $signed({8'd0, rh_s5, 14'd0}) - $signed({{6{h4[11]}}, h4, 20'd0})
			- 38'(h5) * 38'(hv_s5) + 38'sd16384;
		e6_c = 24'(m6_s6 >>> 10);
		e3_c = 24'(m3_s6 >>> 11) + 24'sd32768;
		y0_c = 36'(y1_s7 >>> 10) + 36'sd2097152;
		xs_c = 64'(a2_s8) + 64'h0000_8000_0000_0000;
		pp_c = xs_c * {48'd0, p1};
		pd_c = 21'd1048576 - {1'b0, rp_s8};
		y_c  = 38'((54'(y2_s8) + 54'sd8192) >>> 14);
		sx_c = 64'(hxy_s9) >>> 15;
		sq_c = ll_s10 + {hl_s10[30:0], 1'b0, 32'd0};
		t_c  = 64'($signed(sq_c) >>> 7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1    <= a1_c;
			b1_s1    <= b1_c;
			rp_s1    <= raw_pressure;
			rh_s1    <= raw_humidity;

			m1_s2    <= a1_s1 * t2;
			sq_s2    <= b1_s1 * b1_s1;
			rp_s2    <= rp_s1;
			rh_s2    <= rh_s1;

			ta_s3    <= 24'(m1_s2 >>> 11);
			tb_s3    <= sq12_c * t3;
			rp_s3    <= rp_s2;
			rh_s3    <= rh_s2;

			fine_s4  <= 25'(ta_s3) + 25'(tb_s3 >>> 14);
			rp_s4    <= rp_s3;
			rh_s4    <= rh_s3;

			temp_s5  <= 32'(ft_c >>> 8);
			pv_s5    <= 26'(fine_s4) - 26'(hptc_pkg::P_FINE_OFS);
			hv_s5    <= 26'(fine_s4) - 26'(hptc_pkg::H_FINE_OFS);
			rp_s5    <= rp_s4;
			rh_s5    <= rh_s4;

			aa_s6    <= pv_s5 * pv_s5;
			ap5_s6   <= pv_s5 * p5;
			ap2_s6   <= pv_s5 * p2;
			hx_s6    <= hx_c;
			m6_s6    <= hv_s5 * h6;
			m3_s6    <= hv_s5 * $signed({1'b0, h3});
			rp_s6    <= rp_s5;
			temp_s6  <= temp_s5;

			bb6_s7   <= aa_s6 * p6;
			bb3_s7   <= aa_s6 * p3;
			ap5_s7   <= ap5_s6;
			ap2_s7   <= ap2_s6;
			x_s7     <= 23'(hx_s6 >>> 15);
			y1_s7    <= e6_c * e3_c;
			rp_s7    <= rp_s6;
			temp_s7  <= temp_s6;

			bs_s8    <= bb6_s7 + (64'(ap5_s7) <<< 17) + (64'(p4) <<< 35);
			a2_s8    <= 58'(bb3_s7 >>> 8) + (58'(ap2_s7) <<< 12);
			y2_s8    <= y0_c * h2;
			x_s8     <= x_s7;
			rp_s8    <= rp_s7;
			temp_s8  <= temp_s7;

			den_s9   <= pp_c[63:33];
			diff_s9  <= {12'd0, pd_c, 31'd0} - bs_s8;
			hxy_s9   <= 60'(x_s8) * 60'(y_c);
			temp_s9  <= temp_s8;

			num_s10  <= diff_s9 * 64'd3125;
			den_s10  <= den_s9;
			ll_s10   <= {32'd0, sx_c[31:0]} * {32'd0, sx_c[31:0]};
			hl_s10   <= 32'(sx_c[63:32] * sx_c[31:0]);
			hxy_s10  <= hxy_s9;
			temp_s10 <= temp_s9;

			nmag_s11 <= num_s10[63] ? (64'd0 - num_s10) : num_s10;
			dmag_s11 <= den_s10[30] ? (31'd0 - 31'(den_s10)) : 31'(den_s10);
			qneg_s11 <= num_s10[63] ^ den_s10[30];
			dz_s11   <= (den_s10 == 31'sd0);
			u_s11    <= t_c * {56'd0, h1};
			hxy_s11  <= hxy_s10;
			temp_s11 <= temp_s10;
		end
	end

	// humidity finishes here and rides through the divider
	logic signed [63:0] w_c;
	logic [16:0]        hum_c;
	hptc_pkg::side_t    side_c, dside;
	logic [63:0]        quo;

	always_comb begin
		w_c = 64'(hxy_s11) - ($signed(u_s11) >>> 4);
		if (w_c[63]) begin
			hum_c = '0;
		end else if (w_c > 64'(hptc_pkg::HUM_MAX)) begin
			hum_c = 17'(hptc_pkg::HUM_MAX >> 12);
		end else begin
			hum_c = w_c[28:12];
		end
		side_c.temp = temp_s11;
		side_c.hum  = hum_c;
		side_c.qneg = qneg_s11;
		side_c.dz   = dz_s11;
	end

	hptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.start    (vld_s[11]),
		.num      (nmag_s11),
		.den      (dmag_s11),
		.side     (side_c),
		.fin      (div_fin),
		.quo      (quo),
		.fin_side (dside)
	);

	// stages 76 to 79: pressure correction
	logic signed [63:0] p_s76, p_s77, p_s78, sv_c, sv_s77, t9_s77, t8_s77, b8_s78;
	logic [63:0]        ll9_s78, prod_c;
	logic [31:0]        hl_s78, lh_s78;
	logic signed [63:0] sum_s79, pf_c;
	hptc_pkg::side_t    side_s76, side_s77, side_s78, side_s79;
	logic [23:0]        pres_c;

	always_comb begin
		sv_c   = p_s76 >>> 13;
		prod_c = ll9_s78 + {hl_s78 + lh_s78, 32'd0};
		pf_c   = (sum_s79 >>> 8) + (64'(p7) <<< 4);
		if (side_s79.dz || pf_c[63]) begin
			pres_c = '0;
		end else if (|pf_c[63:32]) begin
			pres_c = 24'hFF_FFFF;
		end else begin
			pres_c = pf_c[31:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s76    <= dside.qneg ? $signed(64'd0 - quo) : $signed(quo);
			side_s76 <= dside;

			sv_s77   <= sv_c;
			t9_s77   <= sv_c * 64'(p9);
			t8_s77   <= p_s76 * 64'(p8);
			p_s77    <= p_s76;
			side_s77 <= side_s76;

			ll9_s78  <= {32'd0, t9_s77[31:0]} * {32'd0, sv_s77[31:0]};
			hl_s78   <= 32'(t9_s77[63:32] * sv_s77[31:0]);
			lh_s78   <= 32'(t9_s77[31:0] * sv_s77[63:32]);
			b8_s78   <= t8_s77 >>> 19;
			p_s78    <= p_s77;
			side_s78 <= side_s77;

			sum_s79  <= p_s78 + ($signed(prod_c) >>> 25) + b8_s78;
			side_s79 <= side_s78;
		end
	end

	// two-beat output buffer
	hptc_pkg::result_t ob_q [2];
	logic              wr_q, rd_q, push, pop;

	assign push = en && vldq_s[79];
	assign pop  = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ob_q[wr_q] <= '{temp: side_s79.temp, pres: pres_c, hum: side_s79.hum};
		end
	end

	assign result_valid      = (cnt_q != 2'd0);
	assign temperature_centi = ob_q[rd_q].temp;
	assign pressure_pa       = ob_q[rd_q].pres;
	assign humidity_q10      = ob_q[rd_q].hum;

endmodule

[src/hptc_chk.sv]
// port-level checks of the compensation unit, bound to the top level
module hptc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [31:0] temperature_centi,
	input logic [23:0]        pressure_pa,
	input logic [16:0]        humidity_q10
);

	// a held result beat stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	// a held result beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(temperature_centi)
			&& $stable(pressure_pa) && $stable(humidity_q10))
		else $error("result payload changed while stalled");

	// intake only stops when results are waiting
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("sample_ready low with no result pending");

	// humidity is clamped to 100 percent
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> humidity_q10 <= 17'd102400)
		else $error("humidity beyond clamp");

endmodule

bind humidity_pressure_temp_compensation_unit hptc_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.sample_ready      (sample_ready),
	.result_valid      (result_valid),
	.result_ready      (result_ready),
	.temperature_centi (temperature_centi),
	.pressure_pa       (pressure_pa),
	.humidity_q10      (humidity_q10)
);
